// ----- src/spg_pkg.sv -----
package spg_pkg;

   // LCG: state = state * MUL + ADD, modulo 2^32
   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;

   // element value width on the store and the result port
   localparam int VAL_W = 7;

   // partner draw: upper half of the generator state, reduced one bit per cycle
   localparam int DVD_W     = 16;
   localparam int DIV_STEPS = DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_FILL = 12'b0000_0000_0010,
      ST_MUL  = 12'b0000_0000_0100,
      ST_ADD  = 12'b0000_0000_1000,
      ST_DIV  = 12'b0000_0001_0000,
      ST_RDI  = 12'b0000_0010_0000,
      ST_RDJ  = 12'b0000_0100_0000,
      ST_WRI  = 12'b0000_1000_0000,
      ST_WRJ  = 12'b0001_0000_0000,
      ST_ORD  = 12'b0010_0000_0000,
      ST_OLD  = 12'b0100_0000_0000,
      ST_OWT  = 12'b1000_0000_0000
   } state_type;

endpackage

// ----- src/seeded_permutation_generator.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid / req_stall | req_seed[31:0], req_count[6:0]
// rsp     | out       | rsp_valid / rsp_stall | rsp_perm_value[6:0], rsp_last
//
// One request at a time; req_stall is high from acceptance until the last item is taken.
// The work per request, with n = min(count, MAX_COUNT): a fill of n store entries, n-1
// swaps, then n outputs; each swap is a multiply, an add, a serial modulo and 4 store
// accesses (two reads, two writes). A count of zero is taken and produces nothing.
// Reset (synchronous, active high) clears the sequencer, generator and output valid.
// rsp_stall only holds the output register; the sequencer waits there.
module seeded_permutation_generator #(
   parameter int MAX_COUNT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_seed,
   input  logic [6:0]             req_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [spg_pkg::VAL_W-1:0] rsp_perm_value,
   output logic                   rsp_last
);

   localparam int IDX_W = $clog2(MAX_COUNT);
   localparam int N_W   = IDX_W + 1;

   spg_pkg::state_type state_ff, state_in;

   logic [31:0]                   gen_ff, gen_in;
   logic [31:0]                   prod_ff, prod_in;
   logic [N_W-1:0]                n_ff, n_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [IDX_W-1:0]              i_ff, i_in;
   logic [spg_pkg::DVD_W-1:0]     dvd_ff, dvd_in;
   logic [IDX_W-1:0]              rem_ff, rem_in;
   logic [spg_pkg::DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [spg_pkg::VAL_W-1:0]     tmp_ff, tmp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [spg_pkg::VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [spg_pkg::VAL_W-1:0]     mem [MAX_COUNT];
   logic [spg_pkg::VAL_W-1:0]     rd_data_ff;
   logic [IDX_W-1:0]              rd_addr;
   logic                          mem_we;
   logic [IDX_W-1:0]              mem_waddr;
   logic [spg_pkg::VAL_W-1:0]     mem_wdata;

   logic [N_W-1:0]                n_sat;
   logic [N_W-1:0]                n_last;
   logic [N_W-1:0]                divisor;
   logic [N_W-1:0]                shifted;
   logic [31:0]                   lcg_next;

   assign n_sat    = (req_count > 7'(MAX_COUNT)) ? N_W'(MAX_COUNT) : N_W'(req_count);
   assign n_last   = n_ff - N_W'(1);
   assign divisor  = {1'b0, i_ff} + N_W'(1);
   assign shifted  = {rem_ff, dvd_ff[spg_pkg::DVD_W-1]};
   assign lcg_next = prod_ff + spg_pkg::LCG_ADD;

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      prod_in      = prod_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      i_in         = i_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = spg_pkg::VAL_W'(idx_ff) + spg_pkg::VAL_W'(1);
      rd_addr      = i_ff;

      unique case (state_ff)
         spg_pkg::ST_IDLE: begin
            if (req_valid && (req_count != 7'd0)) begin
               n_in     = n_sat;
               gen_in   = req_seed;
               idx_in   = '0;
               state_in = spg_pkg::ST_FILL;
            end
         end
         spg_pkg::ST_FILL: begin
            mem_we = 1'b1;
            if ({1'b0, idx_ff} == n_last) begin
               i_in     = idx_ff;
               idx_in   = '0;
               state_in = (idx_ff == '0) ? spg_pkg::ST_ORD : spg_pkg::ST_MUL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         spg_pkg::ST_MUL: begin
            prod_in  = gen_ff * spg_pkg::LCG_MUL;
            state_in = spg_pkg::ST_ADD;
         end
         spg_pkg::ST_ADD: begin
            gen_in   = lcg_next;
            dvd_in   = lcg_next[31:32-spg_pkg::DVD_W];
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = spg_pkg::ST_DIV;
         end
         spg_pkg::ST_DIV: begin
            // restoring remainder, one dividend bit per cycle
            if (shifted >= divisor) begin
               rem_in = IDX_W'(shifted - divisor);
            end else begin
               rem_in = shifted[IDX_W-1:0];
            end
            dvd_in  = {dvd_ff[spg_pkg::DVD_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + spg_pkg::DIV_CNT_W'(1);
            if (dcnt_ff == spg_pkg::DIV_CNT_W'(spg_pkg::DIV_STEPS - 1)) begin
               state_in = spg_pkg::ST_RDI;
            end
         end
         spg_pkg::ST_RDI: begin
            rd_addr  = i_ff;
            state_in = spg_pkg::ST_RDJ;
         end
         spg_pkg::ST_RDJ: begin
            rd_addr  = rem_ff;
            tmp_in   = rd_data_ff;     // store[i]
            state_in = spg_pkg::ST_WRI;
         end
         spg_pkg::ST_WRI: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rd_data_ff;    // store[j]
            state_in  = spg_pkg::ST_WRJ;
         end
         spg_pkg::ST_WRJ: begin
            mem_we    = 1'b1;
            mem_waddr = rem_ff;
            mem_wdata = tmp_ff;
            i_in      = i_ff - IDX_W'(1);
            state_in  = (i_ff == IDX_W'(1)) ? spg_pkg::ST_ORD : spg_pkg::ST_MUL;
         end
         spg_pkg::ST_ORD: begin
            rd_addr  = idx_ff;
            state_in = spg_pkg::ST_OLD;
         end
         spg_pkg::ST_OLD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data_ff;
            rsp_last_in  = ({1'b0, idx_ff} == n_last);
            state_in     = spg_pkg::ST_OWT;
         end
         spg_pkg::ST_OWT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  idx_in   = '0;
                  state_in = spg_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = spg_pkg::ST_ORD;
               end
            end
         end
         default: begin
            state_in = spg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spg_pkg::ST_IDLE;
         gen_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff      <= prod_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      tmp_ff       <= tmp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_stall      = (state_ff != spg_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_perm_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == spg_pkg::ST_OWT))
      else $error("output valid outside output wait");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spg_pkg::ST_DIV) |-> ({1'b0, rem_ff} < divisor))
      else $error("partial remainder not below divisor");

   a_partner_le_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spg_pkg::ST_RDI) |-> (rem_ff <= i_ff))
      else $error("swap partner above index");

   a_start_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_count != 7'd0)) |=> (state_ff == spg_pkg::ST_FILL))
      else $error("accepted item did not start fill");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == spg_pkg::ST_ORD) || (state_ff == spg_pkg::ST_OLD)
       || (state_ff == spg_pkg::ST_OWT)) |-> ({1'b0, idx_ff} <= n_last))
      else $error("output position beyond count");

endmodule

// ----- dv/seeded_permutation_generator_test.sv -----
`timescale 1ns / 1ps

module seeded_permutation_generator_test;

   localparam int MAX_N        = 64;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 100;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [spg_pkg::VAL_W-1:0] value;
      logic                      last;
   } perm_entry_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic [31:0]               req_seed  = '0;
   logic [6:0]                req_count = '0;
   logic                      rsp_stall = 1'b0;
   logic                      req_stall;
   logic                      rsp_valid;
   logic [spg_pkg::VAL_W-1:0] rsp_perm_value;
   logic                      rsp_last;

   perm_entry_type expected_perm[$];
   logic [31:0] lcg_state = '0;

   int idle_pct           = 0;
   int stall_pct          = 0;
   int hold_gen           = 0;
   int perm_errors        = 0;
   int values_checked     = 0;
   int requests_sent      = 0;
   int empty_requests     = 0;
   int saturated_requests = 0;
   int cycle_count        = 0;

   seeded_permutation_generator #(
      .MAX_COUNT(MAX_N)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seed       (req_seed),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_perm_value (rsp_perm_value),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Fisher-Yates over 1..n, partner from upper half of the LCG state
   function automatic void predict_permutation(logic [31:0] seed, logic [6:0] count);
      logic [spg_pkg::VAL_W-1:0] slot [MAX_N];
      logic [spg_pkg::VAL_W-1:0] swap_tmp;
      int n;
      int pick;
      if (count == 0) begin
         empty_requests++;
         return;
      end
      if (count > MAX_N) saturated_requests++;
      n = (count > MAX_N) ? MAX_N : int'(count);
      for (int i = 0; i < n; i++) slot[i] = spg_pkg::VAL_W'(i + 1);
      lcg_state = seed;
      for (int i = n - 1; i > 0; i--) begin
         lcg_state = lcg_state * spg_pkg::LCG_MUL + spg_pkg::LCG_ADD;
         pick = int'(lcg_state[31:16]) % (i + 1);
         swap_tmp = slot[i];
         slot[i] = slot[pick];
         slot[pick] = swap_tmp;
      end
      for (int i = 0; i < n; i++)
         expected_perm.push_back('{value: slot[i], last: (i == n - 1)});
   endfunction

   task automatic send_request(logic [31:0] seed, logic [6:0] count);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_seed  <= seed;
      req_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      predict_permutation(seed, count);
   endtask

   task automatic test_corner_counts();
      idle_pct  = 0;
      stall_pct = 0;
      send_request(32'h0000_0000, 7'd1);
      send_request(32'hFFFF_FFFF, 7'd1);
      send_request(32'h0000_0000, 7'd2);
      send_request(32'hFFFF_FFFF, 7'd2);
      send_request(32'h1234_5678, 7'd0);
      send_request(32'h0000_0000, 7'd64);
      send_request(32'hFFFF_FFFF, 7'd64);
      send_request(32'h8000_0001, 7'd65);
      send_request(32'hDEAD_BEEF, 7'd127);
      send_request(32'h0F0F_0F0F, 7'd63);
      send_request(32'hA5A5_A5A5, 7'd3);
      send_request(32'h5A5A_5A5A, 7'd5);
      send_request(32'h0000_0000, 7'd0);
      send_request(32'h7FFF_FFFF, 7'd7);
      send_request(32'h8000_0000, 7'd32);
      send_request(32'h0001_0000, 7'd16);
      send_request($urandom, 7'd96);
   endtask

   // output held off long enough that the block finishes and the next request waits on req_stall
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      send_request(32'h1357_9BDF, 7'd8);
      hold_gen++;
      repeat (4) send_request($urandom, 7'($urandom_range(1, 12)));
   endtask

   task automatic test_random_shuffles(int n_items, int idle, int stall);
      int sent;
      int r;
      logic [6:0] count;
      idle_pct  = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 3) count = 7'd0;
         else if (r < 65) count = 7'($urandom_range(1, 10));
         else if (r < 85) count = 7'($urandom_range(11, 40));
         else if (r < 95) count = 7'($urandom_range(41, 64));
         else count = 7'($urandom_range(65, 127));
         send_request($urandom, count);
         if (count != 0) sent++;
      end
   endtask

   initial begin : rsp_pacing
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      perm_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_perm.size() == 0) begin
            perm_errors++;
            if (perm_errors <= REPORT_MAX)
               $display("ERROR: unexpected item value=%0d last=%0b", rsp_perm_value, rsp_last);
         end else begin
            want = expected_perm.pop_front();
            values_checked++;
            if (rsp_perm_value !== want.value || rsp_last !== want.last) begin
               perm_errors++;
               if (perm_errors <= REPORT_MAX)
                  $display("ERROR: item %0d expected value=%0d last=%0b, got value=%0d last=%0b",
                           values_checked, want.value, want.last, rsp_perm_value, rsp_last);
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d items outstanding",
               cycle_count, expected_perm.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_counts();
      test_backpressure();
      test_random_shuffles(50, 0, 0);
      test_random_shuffles(50, 80, 0);
      test_random_shuffles(50, 0, 80);
      test_random_shuffles(50, 9, 9);
      req_valid <= 1'b0;

      while (expected_perm.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d zero count, %0d over the maximum), %0d values checked",
               requests_sent, empty_requests, saturated_requests, values_checked);
      $display("Corner counts, long output hold-off, random with sender/receiver idling; "
               , "%0d mismatches", perm_errors);
      if (perm_errors == 0 && expected_perm.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
